[design/lsfe_pkg.sv]
// Shared constants, codes and fade/blend helpers for the LED scanner fade effect core.
package lsfe_pkg;

  // Default frame buffer depth in LEDs.
  localparam int unsigned LedMaxDefault = 256;

  // Head position carries eight fractional bits; the quotient needs 17 bits.
  localparam int unsigned PosBits = 17;

  // Register reset values.
  localparam logic [7:0]  NumLedsReset    = 8'd8;
  localparam logic [15:0] ScanPeriodReset = 16'd2000;
  localparam logic [4:0]  ScanWidthReset  = 5'd3;
  localparam logic [23:0] ScanColorReset  = 24'hFF0000;

  // Input word action codes.
  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_READ    = 2'd3
  } action_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_NUM_LEDS    = 2'd0,
    REG_SCAN_PERIOD = 2'd1,
    REG_SCAN_WIDTH  = 2'd2,
    REG_SCAN_COLOR  = 2'd3
  } cfg_reg_e;

  // round(256 * 2^(-t/16)) for the top four fraction bits of the distance.
  function automatic logic [8:0] pow2_frac(input logic [3:0] t);
    logic [8:0] val;
    case (t)
      4'd0:    val = 9'd256;
      4'd1:    val = 9'd245;
      4'd2:    val = 9'd235;
      4'd3:    val = 9'd225;
      4'd4:    val = 9'd215;
      4'd5:    val = 9'd206;
      4'd6:    val = 9'd197;
      4'd7:    val = 9'd189;
      4'd8:    val = 9'd181;
      4'd9:    val = 9'd173;
      4'd10:   val = 9'd166;
      4'd11:   val = 9'd159;
      4'd12:   val = 9'd152;
      4'd13:   val = 9'd146;
      4'd14:   val = 9'd140;
      default: val = 9'd134;
    endcase
    return val;
  endfunction

  // Blend fraction 255 * 2^-span, span in Q8. Zero from sixteen LEDs on.
  function automatic logic [7:0] fade_frac(input logic [15:0] span);
    logic [8:0]  p;
    logic [16:0] scaled;
    logic [15:0] shifted;
    p       = pow2_frac(span[7:4]);
    scaled  = ({8'b0, p} << 8) - {8'b0, p};
    shifted = scaled[15:0] >> span[11:8];
    if (span[15:12] != 4'd0) begin
      return 8'd0;
    end
    return shifted[15:8];
  endfunction

  // One channel of a toward b by f/256, rounding toward a.
  function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] f);
    logic [15:0] prod;
    if (b >= a) begin
      prod = {8'b0, b - a} * {8'b0, f};
      return a + prod[15:8];
    end
    prod = {8'b0, a - b} * {8'b0, f};
    return a - prod[15:8];
  endfunction

endpackage

[design/led_scanner_fade_effect_core.sv]
// Top level of the LED scanner fade effect: control sequencer, divider and frame buffer.
//
// Input words (action, time_ms, read_index) arrive on a valid/ready channel and
// are taken only while the sequencer is idle. A tick moves the scan window when
// its end is reached, finds the head position with a multiply and a 17-step
// restoring divide, then walks the LEDs within scan_width of the head through a
// read-modify-write of the frame buffer memory, one LED per cycle while the output
// register is free. Each updated LED leaves as one output word, the final one
// flagged by last_o. A tick updates at most 63 LEDs; when the head saturates at
// the strip end the divide is skipped. A read fetches the entry through the
// registered memory read and loads its word into the output register once that is
// free. A restart finishes in the accept cycle; a clear writes black to the n LEDs
// in use, one per cycle. Neither produces a word.
// Output words sit in a single output register, so the sequencer keeps working
// until it needs that register again; a stalled receiver simply holds the LED walk.
// Reset clears the scan window, restores the register defaults and marks every
// frame buffer entry as empty (reads as black) through per-entry valid bits, so no
// clearing pass is needed after reset. Configuration writes are taken at any cycle.
module led_scanner_fade_effect_core
  import lsfe_pkg::*;
#(
  parameter int unsigned MAX_LEDS = LedMaxDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] time_ms_i,
  input  logic [7:0]  read_index_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  led_index_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        last_o
);

  localparam int unsigned AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam logic [8:0]  MaxLedsW = 9'(MAX_LEDS);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_ADV   = 11'b00000000010,
    S_DIST  = 11'b00000000100,
    S_MUL   = 11'b00000001000,
    S_CHK   = 11'b00000010000,
    S_DIV   = 11'b00000100000,
    S_RANGE = 11'b00001000000,
    S_START = 11'b00010000000,
    S_UPD   = 11'b00100000000,
    S_RDOUT = 11'b01000000000,
    S_CLR   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [7:0]  num_leds_q;
  logic [15:0] scan_period_q;
  logic [4:0]  scan_width_q;
  logic [23:0] scan_color_q;

  // Scan window.
  logic [31:0] scan_start_q, scan_end_q;

  // Tick datapath.
  logic [31:0]        time_q;
  logic [31:0]        e_q;
  logic [31:0]        d_q;
  logic [32:0]        bound_q;
  logic [39:0]        num_q;
  logic [15:0]        rem_q;
  logic [PosBits-1:0] nlow_q;
  logic [PosBits-1:0] quo_q;
  logic [4:0]         div_cnt_q;
  logic [7:0]         cur_q;
  logic [7:0]         hi_q;
  logic [7:0]         f_q;
  logic               rd_inrange_q;

  // Frame buffer memory and its per-entry valid bits.
  logic [23:0]         mem [MAX_LEDS];
  logic [MAX_LEDS-1:0] vld_q;
  logic [23:0]         rd_data_q;
  logic                rd_vld_q;
  logic                mem_re, mem_we;
  logic [AW-1:0]       rd_addr;
  logic [23:0]         wr_color;

  // Output register.
  logic        out_valid_q;
  logic [7:0]  out_idx_q;
  logic [23:0] out_color_q;
  logic        out_last_q;
  logic        out_load;
  logic [23:0] out_color_d;

  // Combinational values.
  logic               in_acc, out_free;
  logic [7:0]         n_leds;
  logic [15:0]        per_w;
  logic               adv;
  logic [31:0]        e_w, d_w, half_w;
  logic [15:0]        lim;
  logic [16:0]        lim_p1;
  logic [32:0]        bound_w;
  logic [39:0]        num_w;
  logic [48:0]        numer;
  logic               sat;
  logic [16:0]        trial, tsub;
  logic               tge;
  logic [15:0]        pos, lo_diff;
  logic [12:0]        wq;
  logic [7:0]         lo_w, hi_w;
  logic [16:0]        hi_sum;
  logic [8:0]         hi_raw;
  logic [7:0]         iss_idx;
  logic [15:0]        at_w, dist_w;
  logic [7:0]         f_w;
  logic               last_w;
  logic [23:0]        old_color, new_color;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  always_comb begin
    // Strip length in use and the divisor with a zero period taken as one.
    n_leds = ({1'b0, num_leds_q} > MaxLedsW) ? MaxLedsW[7:0] : num_leds_q;
    per_w  = (scan_period_q == 16'd0) ? 16'd1 : scan_period_q;

    // Window advance and elapsed time.
    adv = (time_q >= scan_end_q);
    e_w = time_q - (adv ? scan_end_q : scan_start_q);

    // Saturation bound: the quotient exceeds lim exactly when the numerator
    // reaches (lim + 1) * per.
    lim     = {n_leds, 8'b0};
    lim_p1  = {1'b0, lim} + 17'd1;
    bound_w = lim_p1 * per_w;

    // Distance from the middle of the period.
    half_w = {17'b0, scan_period_q[15:1]};
    d_w    = (e_q >= half_w) ? (e_q - half_w) : (half_w - e_q);

    num_w = n_leds * d_q;
    numer = {num_q, 9'b0};
    sat   = (numer >= {16'b0, bound_q});

    // One restoring division step.
    trial = {rem_q, nlow_q[PosBits-1]};
    tge   = (trial >= {1'b0, per_w});
    tsub  = trial - {1'b0, per_w};

    // LED range around the head.
    pos     = quo_q[15:0];
    wq      = {scan_width_q, 8'b0};
    lo_diff = pos - {3'b0, wq};
    lo_w    = (pos > {3'b0, wq}) ? lo_diff[15:8] : 8'd0;
    hi_sum  = {1'b0, pos} + {4'b0, wq} + 17'd255;
    hi_raw  = hi_sum[16:8];
    hi_w    = (hi_raw > {1'b0, n_leds}) ? n_leds : hi_raw[7:0];

    // Fade fraction for the LED whose read is being issued.
    iss_idx = (state_q == S_START) ? cur_q : (cur_q + 8'd1);
    at_w    = {iss_idx, 8'b0};
    dist_w  = (at_w >= pos) ? (at_w - pos) : (pos - at_w);
    f_w     = fade_frac(dist_w);

    last_w = (({1'b0, cur_q} + 9'd1) == {1'b0, hi_q});

    // Entries never written since reset read as black.
    old_color = rd_vld_q ? rd_data_q : 24'h000000;
    new_color = {blend8(old_color[23:16], scan_color_q[23:16], f_q),
                 blend8(old_color[15:8],  scan_color_q[15:8],  f_q),
                 blend8(old_color[7:0],   scan_color_q[7:0],   f_q)};
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    rd_addr     = cur_q[AW-1:0];
    wr_color    = new_color;
    out_load    = 1'b0;
    out_color_d = new_color;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (action_e'(action_i))
            ACT_TICK: begin
              state_d = S_ADV;
            end
            ACT_READ: begin
              mem_re  = 1'b1;
              rd_addr = read_index_i[AW-1:0];
              state_d = S_RDOUT;
            end
            ACT_CLEAR: begin
              if (n_leds != 8'd0) begin
                state_d = S_CLR;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_ADV: begin
        state_d = S_DIST;
      end
      S_DIST: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        state_d = sat ? S_RANGE : S_DIV;
      end
      S_DIV: begin
        if (div_cnt_q == 5'd0) begin
          state_d = S_RANGE;
        end
      end
      S_RANGE: begin
        state_d = S_START;
      end
      S_START: begin
        if (cur_q < hi_q) begin
          mem_re  = 1'b1;
          state_d = S_UPD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_UPD: begin
        if (out_free) begin
          mem_we   = 1'b1;
          out_load = 1'b1;
          if (last_w) begin
            state_d = S_IDLE;
          end else begin
            mem_re  = 1'b1;
            rd_addr = iss_idx[AW-1:0];
          end
        end
      end
      S_RDOUT: begin
        out_color_d = rd_inrange_q ? old_color : 24'h000000;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_CLR: begin
        // Black goes to one LED of the strip per cycle, from LED 0 upward.
        mem_we   = 1'b1;
        wr_color = 24'h000000;
        if (last_w) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state, configuration, scan window and valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      num_leds_q    <= NumLedsReset;
      scan_period_q <= ScanPeriodReset;
      scan_width_q  <= ScanWidthReset;
      scan_color_q  <= ScanColorReset;
      scan_start_q  <= '0;
      scan_end_q    <= '0;
      vld_q         <= '0;
      rd_vld_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load | (out_valid_q & ~out_ready_i);
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_NUM_LEDS:    num_leds_q    <= cfg_data_i[7:0];
          REG_SCAN_PERIOD: scan_period_q <= cfg_data_i[15:0];
          REG_SCAN_WIDTH:  scan_width_q  <= cfg_data_i[4:0];
          REG_SCAN_COLOR:  scan_color_q  <= cfg_data_i;
          default:         num_leds_q    <= num_leds_q;
        endcase
      end
      if (in_acc && (action_e'(action_i) == ACT_RESTART)) begin
        scan_start_q <= time_ms_i;
        scan_end_q   <= time_ms_i + {16'b0, scan_period_q};
      end
      if ((state_q == S_ADV) && adv) begin
        scan_start_q <= scan_end_q;
        scan_end_q   <= scan_end_q + {16'b0, scan_period_q};
      end
      if (mem_we) begin
        vld_q[cur_q[AW-1:0]] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  // Frame buffer memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cur_q[AW-1:0]] <= wr_color;
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Tick datapath and output payload.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          time_q       <= time_ms_i;
          cur_q        <= (action_e'(action_i) == ACT_CLEAR) ? 8'd0 : read_index_i;
          hi_q         <= n_leds;
          rd_inrange_q <= ({1'b0, read_index_i} < MaxLedsW);
        end
      end
      S_ADV: begin
        e_q     <= e_w;
        bound_q <= bound_w;
      end
      S_DIST: begin
        d_q <= d_w;
      end
      S_MUL: begin
        num_q <= num_w;
      end
      S_CHK: begin
        // Without saturation the upper numerator bits are already below the divisor.
        rem_q     <= numer[32:17];
        nlow_q    <= numer[PosBits-1:0];
        div_cnt_q <= 5'(PosBits - 1);
        quo_q     <= sat ? {1'b0, lim} : '0;
      end
      S_DIV: begin
        rem_q     <= tge ? tsub[15:0] : trial[15:0];
        nlow_q    <= {nlow_q[PosBits-2:0], 1'b0};
        quo_q     <= {quo_q[PosBits-2:0], tge};
        div_cnt_q <= div_cnt_q - 5'd1;
      end
      S_RANGE: begin
        cur_q <= lo_w;
        hi_q  <= hi_w;
      end
      S_START: begin
        f_q <= f_w;
      end
      S_UPD: begin
        if (out_free && !last_w) begin
          cur_q <= iss_idx;
          f_q   <= f_w;
        end
      end
      S_CLR: begin
        if (!last_w) begin
          cur_q <= iss_idx;
        end
      end
      S_RDOUT: begin
        f_q <= f_q;
      end
      default: begin
        f_q <= f_q;
      end
    endcase
    if (out_load) begin
      out_idx_q   <= cur_q;
      out_color_q <= out_color_d;
      out_last_q  <= (state_q == S_RDOUT) ? 1'b1 : last_w;
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_index_o = out_idx_q;
  assign red_o       = out_color_q[23:16];
  assign green_o     = out_color_q[15:8];
  assign blue_o      = out_color_q[7:0];
  assign last_o      = out_last_q;

  // While dividing, the divider remainder stays below the divisor.
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> ({1'b0, rem_q} < {1'b0, per_w}))
    else $error("divider remainder not below divisor");

  // The head position never passes the end of the strip.
  a_pos_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RANGE) |-> (quo_q <= {1'b0, lim}))
    else $error("head position beyond strip end");

  // The LED walk only runs inside its range.
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (cur_q < hi_q))
    else $error("LED walk outside its range");

  // Every write-back of the LED walk is reported in the output register on the next cycle.
  a_write_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q == S_UPD)) |=> (out_valid_o && (led_index_o == $past(cur_q))))
    else $error("written LED not reported");

endmodule

[tb/led_scanner_fade_effect_core_tb.sv]
// Self-checking testbench for the LED scanner fade effect core with a built-in scan predictor.
`timescale 1ns / 1ps

module led_scanner_fade_effect_core_tb;
  import lsfe_pkg::*;

  // A clear walks at most 255 LEDs and a tick that updates no LED only runs its
  // multiply and divide, so these idle cycles guarantee that a clear or a tick
  // which updates no LED has finished as well.
  localparam int unsigned DRAIN_CYCLES = 300;
  // The limit sits well above the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  // The receiver holds off this long once, so the core fills up and stalls.
  localparam int unsigned LONG_HOLD = 600;
  localparam int unsigned MAX_REPORTS = 40;

  // One output word as it leaves the core, packed in port order.
  typedef struct packed {
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } led_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_NUM_LEDS;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = ACT_TICK;
  logic [31:0] time_ms_i = '0;
  logic [7:0]  read_index_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  led_index_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic        last_o;

  led_scanner_fade_effect_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .time_ms_i    (time_ms_i),
    .read_index_i (read_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .led_index_o  (led_index_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .last_o       (last_o)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scan predictor state: the testbench's own copy of the frame, the scan
  // window and the four registers; frame and window follow accepted words.
  // ---------------------------------------------------------------------------
  logic [23:0] frame_mem [256];
  logic [31:0] win_start = '0;
  logic [31:0] win_end = '0;
  logic [7:0]  cfg_leds = NumLedsReset;
  logic [15:0] cfg_period = ScanPeriodReset;
  logic [4:0]  cfg_width = ScanWidthReset;
  logic [23:0] cfg_color = ScanColorReset;

  // Fraction of 2^(-t/16), scaled by 256, indexed by the top four fraction bits.
  int unsigned exp2_frac [16] = '{256, 245, 235, 225, 215, 206, 197, 189,
                                  181, 173, 166, 159, 152, 146, 140, 134};

  // LED words the core still owes, oldest first.
  led_word_t led_words_due [$];

  int unsigned err_cnt = 0;
  int unsigned words_checked = 0;
  int unsigned items_sent = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_req = 0;
  bit          idle_on = 1'b1;

  initial begin
    for (int i = 0; i < 256; i++) begin
      frame_mem[i] = '0;
    end
  end

  // Blend factor 255 * 2^-span for a distance with eight fractional bits.
  function automatic logic [7:0] fade_level(longint unsigned span);
    longint unsigned whole;
    int unsigned     frac;
    whole = span >> 8;
    frac = exp2_frac[(span >> 4) & 15];
    if (whole >= 16) begin
      return 8'd0;
    end
    return 8'((255 * frac) >> (8 + whole));
  endfunction

  // Move one color channel from cur toward tgt by f/256, truncating toward cur.
  function automatic logic [7:0] mix_channel(logic [7:0] cur, logic [7:0] tgt, logic [7:0] f);
    int unsigned a;
    int unsigned b;
    a = cur;
    b = tgt;
    if (b >= a) begin
      return 8'(a + (((b - a) * f) >> 8));
    end
    return 8'(a - (((a - b) * f) >> 8));
  endfunction

  // Apply one accepted input word to the predictor and queue the LED words it
  // causes. Ticks walk the LEDs around the triangle-wave head position.
  function automatic void predict_word(action_e act, logic [31:0] t, logic [7:0] ridx);
    longint unsigned n;
    longint unsigned per;
    longint unsigned delta64;
    longint unsigned pos;
    longint unsigned lim;
    longint unsigned wq;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned i;
    longint unsigned at;
    longint unsigned span;
    logic [31:0]     elapsed;
    logic [31:0]     half;
    logic [31:0]     delta;
    logic [7:0]      fr;
    logic [23:0]     old_rgb;
    logic [23:0]     new_rgb;
    int unsigned     cnt;
    n = cfg_leds;
    case (act)
      ACT_RESTART: begin
        win_start = t;
        win_end = t + 32'(cfg_period);
      end
      ACT_CLEAR: begin
        for (i = 0; i < n; i++) begin
          frame_mem[i] = '0;
        end
      end
      ACT_READ: begin
        led_words_due.push_back({ridx, frame_mem[ridx], 1'b1});
      end
      default: begin
        // A zero period still divides as one, but the window adds zero.
        per = (cfg_period == 0) ? 1 : cfg_period;
        if (t >= win_end) begin
          win_start = win_end;
          win_end = win_end + 32'(cfg_period);
        end
        elapsed = t - win_start;
        half = 32'(cfg_period) >> 1;
        delta = (elapsed >= half) ? elapsed - half : half - elapsed;
        delta64 = delta;
        pos = (n * delta64 * 512) / per;
        lim = n << 8;
        if (pos > lim) begin
          pos = lim;
        end
        wq = 64'(cfg_width) << 8;
        lo = (pos > wq) ? (pos - wq) >> 8 : 0;
        hi = (pos + wq + 255) >> 8;
        if (hi > n) begin
          hi = n;
        end
        cnt = 0;
        for (i = lo; i < hi && cnt < 64; i++) begin
          at = i << 8;
          span = (at >= pos) ? at - pos : pos - at;
          fr = fade_level(span);
          old_rgb = frame_mem[i];
          new_rgb = {mix_channel(old_rgb[23:16], cfg_color[23:16], fr),
                     mix_channel(old_rgb[15:8], cfg_color[15:8], fr),
                     mix_channel(old_rgb[7:0], cfg_color[7:0], fr)};
          frame_mem[i] = new_rgb;
          led_words_due.push_back({8'(i), new_rgb, ((i + 1 == hi) || (cnt == 63))});
          cnt++;
        end
      end
    endcase
  endfunction

  // One line per mismatch, capped so a broken core cannot flood the log.
  task automatic report_mismatch(string what, led_word_t seen, led_word_t want);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("ERROR %s: got idx %0d rgb %06h last %0b, want idx %0d rgb %06h last %0b",
               what, seen.idx, {seen.red, seen.green, seen.blue}, seen.last,
               want.idx, {want.red, want.green, want.blue}, want.last);
    end
  endtask

  // Every accepted output word is matched against the oldest word still due.
  always @(posedge clk_i) begin : check_words
    led_word_t seen;
    led_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = {led_index_o, red_o, green_o, blue_o, last_o};
      if (led_words_due.size() == 0) begin
        report_mismatch("word with none due", seen, '0);
      end else begin
        want = led_words_due.pop_front();
        if (seen !== want) begin
          report_mismatch("word differs", seen, want);
        end
        words_checked++;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_cnt,
               led_words_due.size());
      $display("led_scanner_fade_effect_core verification failed");
      $finish;
    end
  end

  // Receiver: a random hold-off before each word, or one long hold when the
  // stall test asks for it. The long hold is counted here, in cycles.
  initial begin : receiver
    int unsigned gap;
    int unsigned hold;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req != 0) begin
        hold = hold_req;
        hold_req = 0;
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      gap = idle_on ? $urandom_range(0, 13) : 0;
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o && hold_req == 0);
    end
  end

  // Offer one input word, wait for it to be taken, then feed the predictor.
  // Called and returning just after a rising edge; valid stays high when the
  // next word follows without a gap.
  task automatic send_word(action_e act, logic [31:0] t, logic [7:0] ridx);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    time_ms_i <= t;
    read_index_i <= ridx;
    do @(posedge clk_i); while (!in_ready_o);
    predict_word(act, t, ridx);
    items_sent++;
  endtask

  // Stop offering words and wait until the core has delivered everything
  // and has had time to finish a clear or a tick that updates no LED.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (led_words_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all four registers back to back once the core is idle. Bits above
  // each register's width carry junk, which the core must drop.
  task automatic set_config(logic [7:0] leds, logic [15:0] period, logic [4:0] width,
                            logic [23:0] color);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_NUM_LEDS;
    cfg_data_i <= {16'($urandom), leds};
    @(posedge clk_i);
    cfg_idx_i <= REG_SCAN_PERIOD;
    cfg_data_i <= {8'($urandom), period};
    @(posedge clk_i);
    cfg_idx_i <= REG_SCAN_WIDTH;
    cfg_data_i <= {19'($urandom), width};
    @(posedge clk_i);
    cfg_idx_i <= REG_SCAN_COLOR;
    cfg_data_i <= color;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_leds = leds;
    cfg_period = period;
    cfg_width = width;
    cfg_color = color;
    settings_used++;
  endtask

  // Reset state: an empty frame reads black, and the default registers scan
  // eight LEDs in red with the window still at zero.
  task automatic test_reset_state();
    send_word(ACT_READ, 32'd0, 8'd0);
    send_word(ACT_READ, 32'd0, 8'd255);
    send_word(ACT_TICK, 32'd0, 8'd0);
    send_word(ACT_READ, 32'd0, 8'd7);
  endtask

  // Directed corners: widest strip and lit region, longest, zero and one
  // periods, an empty strip, time before the scan start, reads past the strip.
  task automatic test_extremes();
    set_config(8'd255, 16'd65535, 5'd31, 24'hFFFFFF);
    send_word(ACT_RESTART, 32'd0, 8'd0);
    send_word(ACT_TICK, 32'd0, 8'd0);
    // Head at LED 0, the lit region clipped at the strip start.
    send_word(ACT_TICK, 32'd32767, 8'd0);
    // Window advances once, elapsed is huge and the head saturates.
    send_word(ACT_TICK, 32'hFFFF_FFFF, 8'hFF);
    send_word(ACT_CLEAR, 32'd0, 8'd0);
    send_word(ACT_READ, 32'd0, 8'd254);

    // Empty strip with a zero period: ticks and clear touch nothing.
    set_config(8'd0, 16'd0, 5'd0, 24'h000000);
    send_word(ACT_TICK, 32'd5, 8'd0);
    send_word(ACT_CLEAR, 32'd0, 8'd0);
    send_word(ACT_READ, 32'd0, 8'd3);
    send_word(ACT_RESTART, 32'd100, 8'd0);

    set_config(8'd1, 16'd1, 5'd0, 24'h00FF00);
    send_word(ACT_TICK, 32'd100, 8'd0);
    send_word(ACT_TICK, 32'd101, 8'd0);
    send_word(ACT_READ, 32'd0, 8'd0);

    // A time just before the scan start wraps the elapsed time.
    set_config(8'd16, 16'd2, 5'd1, 24'h0000FF);
    send_word(ACT_RESTART, 32'd1000, 8'd0);
    send_word(ACT_TICK, 32'd999, 8'd0);
    send_word(ACT_TICK, 32'd1001, 8'd0);
    send_word(ACT_READ, 32'd0, 8'd15);
    send_word(ACT_READ, 32'd0, 8'd200);
  endtask

  // One phase of random scanning: a random setting, a restart, then mostly
  // ticks at advancing times mixed with reads, clears, restarts and noise.
  task automatic test_random_scan(int unsigned count);
    int unsigned pick;
    int unsigned step_max;
    logic [7:0]  leds;
    logic [15:0] period;
    logic [4:0]  width;
    logic [23:0] color;
    logic [31:0] cur_t;
    logic [7:0]  ridx;
    pick = $urandom_range(0, 3);
    leds = (pick == 0) ? 8'd1 : (pick == 1) ? 8'd255 :
           (pick == 2) ? 8'($urandom_range(2, 40)) : 8'($urandom_range(1, 255));
    pick = $urandom_range(0, 3);
    period = (pick == 0) ? 16'd2 : (pick == 1) ? 16'd65535 :
             (pick == 2) ? 16'($urandom_range(2, 400)) : 16'($urandom_range(2, 65535));
    pick = $urandom_range(0, 5);
    width = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd31 : 5'($urandom_range(1, 6));
    pick = $urandom_range(0, 3);
    color = (pick == 0) ? 24'h000000 : (pick == 1) ? 24'hFFFFFF : 24'($urandom);
    set_config(leds, period, width, color);

    // Sometimes start near the top of the time range so the window wraps.
    cur_t = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3 * period) :
            $urandom;
    send_word(ACT_RESTART, cur_t, 8'($urandom));
    step_max = period / 6 + 2;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_word(ACT_TICK, cur_t, 8'($urandom));
        cur_t = cur_t + $urandom_range(0, step_max);
      end else if (pick < 78) begin
        ridx = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, leds)) : 8'($urandom);
        send_word(ACT_READ, $urandom, ridx);
      end else if (pick < 83) begin
        send_word(ACT_CLEAR, $urandom, 8'($urandom));
      end else if (pick < 89) begin
        cur_t = cur_t + $urandom_range(0, period);
        send_word(ACT_RESTART, cur_t, 8'($urandom));
      end else if (pick < 95) begin
        send_word(ACT_TICK, $urandom, 8'($urandom));
      end else begin
        send_word(ACT_TICK, win_start - $urandom_range(1, 50), 8'($urandom));
      end
    end
  endtask

  // The receiver stops for a long stretch while ticks keep coming, so the
  // output register fills, the LED walk holds and the input side stalls.
  task automatic test_output_stall();
    set_config(8'd64, 16'd1000, 5'd6, 24'h3080FF);
    hold_req = LONG_HOLD;
    send_word(ACT_RESTART, 32'd0, 8'd0);
    for (int k = 1; k <= 8; k++) begin
      send_word(ACT_TICK, 32'(k * 110), 8'd0);
    end
    wait_idle();
  endtask

  // Back-to-back words on both sides with no idling at all.
  task automatic test_steady_stream();
    wait_idle();
    idle_on = 1'b0;
    test_random_scan(30);
    wait_idle();
    idle_on = 1'b1;
  endtask

  initial begin : main
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_extremes();
    for (int ph = 0; ph < 8; ph++) begin
      test_random_scan(38);
    end
    test_output_stall();
    test_steady_stream();
    wait_idle();

    if (led_words_due.size() != 0) begin
      report_mismatch("word never arrived", '0, led_words_due[0]);
    end
    $display("Sent %0d input words across %0d register settings, checked %0d LED words.",
             items_sent, settings_used, words_checked);
    $display("Covered reset, corners, random scans, a long stall, a steady stream; %0d errors.",
             err_cnt);
    if (err_cnt == 0) begin
      $display("led_scanner_fade_effect_core verification clean");
    end else begin
      $display("led_scanner_fade_effect_core verification failed");
    end
    $finish;
  end

endmodule
